[rtl/rc4_pkg.sv]
// ----------------------------------------------------------------------------
// RC4 package
// Shared widths, sizes and codes of the RC4 stream cipher.
// ----------------------------------------------------------------------------
package rc4_pkg;

    // Byte and permutation index width.
    localparam int BYTE_W = 8;

    // Entries in the permutation memory.
    localparam int SBOX_DEPTH = 256;

    // Last index of the permutation, where the sweeps end.
    localparam logic [BYTE_W-1:0] IDX_LAST = 8'hFF;

    // Word kinds carried in tuser.
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

endpackage

[rtl/rc4_ram.sv]
// ----------------------------------------------------------------------------
// RC4 byte memory
// Simple dual-port byte memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [rc4_pkg::BYTE_W-1:0]  wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [rc4_pkg::BYTE_W-1:0]  rdata
);

    logic [rc4_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [rc4_pkg::BYTE_W-1:0] rdata_reg;

    // A read in the cycle of a write to the same entry returns the old data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rc4_stream_cipher.sv]
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Byte-wide RC4 with key loading, key schedule and keystream generation.
// ----------------------------------------------------------------------------
// Words with tuser low are key bytes: each is stored in the key memory until
// MAX_KEY_BYTES bytes are held, later ones are dropped, and the key word with
// tlast high starts the key schedule. The schedule first rewrites the
// permutation memory to identity and then runs 256 key-mixing swaps, each
// reading S[i] and the key byte, reading S[j] and writing both back, so a
// final key word keeps the input closed until the schedule ends. After
// reset the same identity pass runs alone, and no word is taken until it
// ends. Words with tuser high are data bytes: each passes through accept,
// two dependent reads of the permutation memory, and the read of the
// keystream entry, in steps set by the single read port and single write
// port of the permutation memory; a full output register that is not
// drained stalls the last step. One result word comes out per data word,
// with tlast copied; key words give no result. The input is open again as
// soon as a result enters the output register, so one finished word may
// wait at the output while the next one is being worked on.
// ----------------------------------------------------------------------------
module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] opcode: key byte or data byte
    input  logic        s_tlast,   // last_in

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] byte_out
    output logic        m_tlast    // last_out
);

    localparam int BW = rc4_pkg::BYTE_W;
    // Key memory address and key counter widths.
    localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KCW = $clog2(MAX_KEY_BYTES + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_MIX_RD,
        ST_MIX_ACC,
        ST_MIX_WA,
        ST_MIX_WB,
        ST_GEN_J,
        ST_GEN_SW,
        ST_GEN_OUT
    } state_t;

    state_t          st_reg, st_next;
    logic [KCW-1:0]  key_count_reg, key_count_next;
    logic [KCW-1:0]  len_reg, len_next;
    logic [KAW-1:0]  kpos_reg, kpos_next;
    logic            sched_reg, sched_next;
    logic [BW-1:0]   n_reg, n_next;
    logic [BW-1:0]   acc_reg, acc_next;
    logic [BW-1:0]   idx_i_reg, idx_i_next;
    logic [BW-1:0]   idx_j_reg, idx_j_next;
    logic [BW-1:0]   si_reg, si_next;
    logic [BW-1:0]   sj_reg, sj_next;
    logic [BW-1:0]   t_reg, t_next;
    logic [BW-1:0]   byte_reg, byte_next;
    logic            last_reg, last_next;
    logic            m_valid_reg, m_valid_next;
    logic [BW-1:0]   m_data_reg, m_data_next;
    logic            m_last_reg, m_last_next;

    // Permutation memory ports.
    logic            sb_we, sb_re;
    logic [BW-1:0]   sb_waddr, sb_wdata, sb_raddr, sb_rdata;
    // Key memory ports.
    logic            kr_we, kr_re;
    logic [KAW-1:0]  kr_waddr, kr_raddr;
    logic [BW-1:0]   kr_wdata, kr_rdata;

    logic [KCW-1:0]  cnt_inc;
    logic [KCW-1:0]  kpos_ext;
    logic [BW-1:0]   keystream;

    rc4_ram #(
        .DEPTH  (rc4_pkg::SBOX_DEPTH),
        .ADDR_W (BW)
    ) u_sbox (
        .aclk  (aclk),
        .we    (sb_we),
        .waddr (sb_waddr),
        .wdata (sb_wdata),
        .re    (sb_re),
        .raddr (sb_raddr),
        .rdata (sb_rdata)
    );

    rc4_ram #(
        .DEPTH  (MAX_KEY_BYTES),
        .ADDR_W (KAW)
    ) u_key (
        .aclk  (aclk),
        .we    (kr_we),
        .waddr (kr_waddr),
        .wdata (kr_wdata),
        .re    (kr_re),
        .raddr (kr_raddr),
        .rdata (kr_rdata)
    );

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    assign cnt_inc  = key_count_reg + KCW'(1);
    assign kpos_ext = KCW'(kpos_reg) + KCW'(1);

    // The keystream entry was read in the cycle that wrote S[i]; S[j] is
    // written in the next cycle. Forward both swapped values, S[j] winning
    // since it is the later write.
    always_comb begin
        if (t_reg == idx_j_reg) begin
            keystream = si_reg;
        end else if (t_reg == idx_i_reg) begin
            keystream = sj_reg;
        end else begin
            keystream = sb_rdata;
        end
    end

    always_comb begin
        st_next        = st_reg;
        key_count_next = key_count_reg;
        len_next       = len_reg;
        kpos_next      = kpos_reg;
        sched_next     = sched_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        idx_i_next     = idx_i_reg;
        idx_j_next     = idx_j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        t_next         = t_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;

        sb_we    = 1'b0;
        sb_waddr = n_reg;
        sb_wdata = n_reg;
        sb_re    = 1'b0;
        sb_raddr = n_reg;
        kr_we    = 1'b0;
        kr_waddr = key_count_reg[KAW-1:0];
        kr_wdata = s_tdata;
        kr_re    = 1'b0;
        kr_raddr = kpos_reg;

        case (st_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == rc4_pkg::OP_DATA) begin
                        idx_i_next = idx_i_reg + BW'(1);
                        sb_re      = 1'b1;
                        sb_raddr   = idx_i_reg + BW'(1);
                        byte_next  = s_tdata;
                        last_next  = s_tlast;
                        st_next    = ST_GEN_J;
                    end else begin
                        if (key_count_reg < KCW'(MAX_KEY_BYTES)) begin
                            kr_we          = 1'b1;
                            key_count_next = cnt_inc;
                        end
                        if (s_tlast) begin
                            len_next       = (key_count_reg < KCW'(MAX_KEY_BYTES)) ?
                                             cnt_inc : key_count_reg;
                            key_count_next = '0;
                            idx_i_next     = '0;
                            idx_j_next     = '0;
                            sched_next     = 1'b1;
                            n_next         = '0;
                            st_next        = ST_INIT;
                        end
                    end
                end
            end
            ST_INIT: begin
                sb_we  = 1'b1;
                n_next = n_reg + BW'(1);
                if (n_reg == rc4_pkg::IDX_LAST) begin
                    acc_next  = '0;
                    kpos_next = '0;
                    st_next   = sched_reg ? ST_MIX_RD : ST_IDLE;
                end
            end
            ST_MIX_RD: begin
                sb_re   = 1'b1;
                kr_re   = 1'b1;
                st_next = ST_MIX_ACC;
            end
            ST_MIX_ACC: begin
                acc_next = acc_reg + sb_rdata + kr_rdata;
                si_next  = sb_rdata;
                sb_re    = 1'b1;
                sb_raddr = acc_reg + sb_rdata + kr_rdata;
                st_next  = ST_MIX_WA;
            end
            ST_MIX_WA: begin
                sb_we    = 1'b1;
                sb_wdata = sb_rdata;
                st_next  = ST_MIX_WB;
            end
            ST_MIX_WB: begin
                sb_we    = 1'b1;
                sb_waddr = acc_reg;
                sb_wdata = si_reg;
                n_next   = n_reg + BW'(1);
                // The key repeats cyclically over its stored length.
                if (kpos_ext >= len_reg) begin
                    kpos_next = '0;
                end else begin
                    kpos_next = kpos_ext[KAW-1:0];
                end
                if (n_reg == rc4_pkg::IDX_LAST) begin
                    sched_next = 1'b0;
                    st_next    = ST_IDLE;
                end else begin
                    st_next = ST_MIX_RD;
                end
            end
            ST_GEN_J: begin
                si_next    = sb_rdata;
                idx_j_next = idx_j_reg + sb_rdata;
                sb_re      = 1'b1;
                sb_raddr   = idx_j_reg + sb_rdata;
                st_next    = ST_GEN_SW;
            end
            ST_GEN_SW: begin
                sj_next  = sb_rdata;
                sb_we    = 1'b1;
                sb_waddr = idx_i_reg;
                sb_wdata = sb_rdata;
                t_next   = si_reg + sb_rdata;
                sb_re    = 1'b1;
                sb_raddr = si_reg + sb_rdata;
                st_next  = ST_GEN_OUT;
            end
            ST_GEN_OUT: begin
                // Rewriting S[j] while waiting for the output is harmless.
                sb_we    = 1'b1;
                sb_waddr = idx_j_reg;
                sb_wdata = si_reg;
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = byte_reg ^ keystream;
                    m_last_next  = last_reg;
                    st_next      = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_INIT;
            key_count_reg <= '0;
            sched_reg     <= 1'b0;
            n_reg         <= '0;
            idx_i_reg     <= '0;
            idx_j_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            st_reg        <= st_next;
            key_count_reg <= key_count_next;
            sched_reg     <= sched_next;
            n_reg         <= n_next;
            idx_i_reg     <= idx_i_next;
            idx_j_reg     <= idx_j_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg    <= len_next;
        kpos_reg   <= kpos_next;
        acc_reg    <= acc_next;
        si_reg     <= si_next;
        sj_reg     <= sj_next;
        t_reg      <= t_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    // The key counter never passes the size of the key memory.
    a_key_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        key_count_reg <= KCW'(MAX_KEY_BYTES))
        else $error("key count beyond key memory size");

    // The key position stays inside the stored key while mixing.
    a_kpos_in_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_MIX_RD) |-> (KCW'(kpos_reg) < len_reg))
        else $error("key position outside stored key");

    // A result enters the output register only from the last data step.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg && !m_tready)) |->
            $past(st_reg == ST_GEN_OUT))
        else $error("result word without a finished data word");

    // A final key word always starts the identity pass of the schedule.
    a_sched_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == rc4_pkg::OP_KEY) && s_tlast) |=>
            (st_reg == ST_INIT) && sched_reg)
        else $error("final key word did not start the key schedule");

endmodule
